FILE: hw/rtl/ucd_pkg.sv
package ucd_pkg;

  localparam int unsigned VERT_W     = 10;
  localparam int unsigned NUM_VERT   = 1 << VERT_W;
  localparam int unsigned MAX_EDGES  = 4096;
  localparam int unsigned EDGE_CNT_W = 13;
  localparam int unsigned VCOUNT_W   = 11;
  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = VCOUNT_W'(NUM_VERT);

  typedef logic [VERT_W-1:0] vert_t;

  // One entry of the forest store: the link toward the root and, valid at
  // roots only, whether the component holds a cycle.
  typedef struct packed {
    logic  cyc;
    vert_t par;
  } node_t;

  typedef enum logic [9:0] {
    S_CLEAR      = 10'b00_0000_0001,
    S_IDLE       = 10'b00_0000_0010,
    S_DECIDE     = 10'b00_0000_0100,
    S_FIND_U     = 10'b00_0000_1000,
    S_FIND_V     = 10'b00_0001_0000,
    S_LINK_A     = 10'b00_0010_0000,
    S_LINK_B     = 10'b00_0100_0000,
    S_SCAN_START = 10'b00_1000_0000,
    S_SCAN_FIND  = 10'b01_0000_0000,
    S_RESULT     = 10'b10_0000_0000
  } state_t;

  typedef struct packed {
    logic clear_start;
    logic clear_step;
    logic accept;
    logic follow;
    logic take_u;
    logic take_v;
    logic link_a;
    logic link_b;
    logic scan_start;
    logic scan_next;
    logic mark_found;
  } cmd_t;

  typedef struct packed {
    logic is_root;
    logic root_cyc;
    logic clear_done;
    logic scan_done;
    logic stored;
    logic last;
    logic ovf;
  } stat_t;

endpackage

FILE: hw/rtl/ucd_edge_if.sv
interface ucd_edge_if
  import ucd_pkg::*;
;
  logic  valid;
  logic  ready;
  vert_t edge_u;
  vert_t edge_v;
  logic  has_edge;
  logic  last_edge;

  modport source (output valid, edge_u, edge_v, has_edge, last_edge, input ready);
  modport sink   (input valid, edge_u, edge_v, has_edge, last_edge, output ready);
endinterface

FILE: hw/rtl/ucd_result_if.sv
interface ucd_result_if;
  logic valid;
  logic ready;
  logic cycle_found;
  logic overflow;

  modport source (output valid, cycle_found, overflow, input ready);
  modport sink   (input valid, cycle_found, overflow, output ready);
endinterface

FILE: hw/rtl/ucd_ctrl.sv
module ucd_ctrl
  import ucd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  output cmd_t  cmd,
  input  stat_t stat
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_RESULT);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.stored) begin
          state_next = S_FIND_U;
        end else if (stat.last) begin
          state_next = stat.ovf ? S_RESULT : S_SCAN_START;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_FIND_U: begin
        if (stat.is_root) begin
          cmd.take_u = 1'b1;
          state_next = S_FIND_V;
        end else begin
          cmd.follow = 1'b1;
        end
      end
      S_FIND_V: begin
        if (stat.is_root) begin
          cmd.take_v = 1'b1;
          state_next = S_LINK_A;
        end else begin
          cmd.follow = 1'b1;
        end
      end
      S_LINK_A: begin
        cmd.link_a = 1'b1;
        state_next = S_LINK_B;
      end
      S_LINK_B: begin
        cmd.link_b = 1'b1;
        if (stat.last) begin
          state_next = stat.ovf ? S_RESULT : S_SCAN_START;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SCAN_START: begin
        if (stat.scan_done) begin
          state_next = S_RESULT;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN_FIND;
        end
      end
      S_SCAN_FIND: begin
        if (stat.is_root) begin
          if (stat.root_cyc) begin
            cmd.mark_found = 1'b1;
            state_next     = S_RESULT;
          end else begin
            cmd.scan_next = 1'b1;
            state_next    = S_SCAN_START;
          end
        end else begin
          cmd.follow = 1'b1;
        end
      end
      S_RESULT: begin
        if (out_ready) begin
          cmd.clear_start = 1'b1;
          state_next      = S_CLEAR;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

FILE: hw/rtl/ucd_datapath.sv
module ucd_datapath
  import ucd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [VCOUNT_W-1:0] cfg_data,
  input  vert_t               edge_u,
  input  vert_t               edge_v,
  input  logic                has_edge,
  input  logic                last_edge,
  input  cmd_t                cmd,
  output stat_t               stat,
  output logic                cycle_found,
  output logic                overflow
);

  node_t mem [NUM_VERT];
  node_t q;

  vert_t                 edge_v_r;
  logic                  last_r;
  logic                  stored_r;
  logic [EDGE_CNT_W-1:0] count;
  logic                  ovf;
  logic                  found;
  vert_t                 cur, cur_next;
  vert_t                 ru, rv;
  logic                  cu, cv;
  logic [VCOUNT_W-1:0]   s;
  vert_t                 clr_idx;
  logic [VCOUNT_W-1:0]   vcount;
  logic [VCOUNT_W-1:0]   limit;
  logic                  full;
  logic                  we;
  vert_t                 wa;
  node_t                 wd;

  assign full  = (count == EDGE_CNT_W'(MAX_EDGES));
  assign limit = (vcount > VCOUNT_W'(NUM_VERT)) ? VCOUNT_W'(NUM_VERT) : vcount;

  // The read address follows the next pointer, so q shows the entry of cur;
  // both are registered on the same edge.
  always_comb begin
    cur_next = cur;
    if (cmd.accept) begin
      cur_next = edge_u;
    end else if (cmd.follow) begin
      cur_next = q.par;
    end else if (cmd.take_u) begin
      cur_next = edge_v_r;
    end else if (cmd.scan_start) begin
      cur_next = s[VERT_W-1:0];
    end
  end

  always_comb begin
    we = 1'b0;
    wa = clr_idx;
    wd = '{cyc: 1'b0, par: clr_idx};
    if (cmd.clear_step) begin
      we = 1'b1;
    end else if (cmd.link_a) begin
      we = 1'b1;
      wa = ru;
      wd = '{cyc: 1'b0, par: rv};
    end else if (cmd.link_b) begin
      we = 1'b1;
      wa = rv;
      wd = '{cyc: cu | cv | (ru == rv), par: rv};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    q <= mem[cur_next];
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    if (cmd.accept) begin
      edge_v_r <= edge_v;
    end
    if (cmd.take_u) begin
      ru <= cur;
      cu <= q.cyc;
    end
    if (cmd.take_v) begin
      rv <= cur;
      cv <= q.cyc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= VCOUNT_RESET;
    end else if (cfg_write) begin
      vcount <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_start) begin
      count    <= '0;
      ovf      <= 1'b0;
      found    <= 1'b0;
      s        <= '0;
      clr_idx  <= '0;
      last_r   <= 1'b0;
      stored_r <= 1'b0;
    end else begin
      if (cmd.clear_step) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (cmd.accept) begin
        last_r   <= last_edge;
        stored_r <= has_edge & ~full;
        if (has_edge && !full) begin
          count <= count + 1'b1;
        end
        if (has_edge && full) begin
          ovf <= 1'b1;
        end
      end
      if (cmd.scan_next) begin
        s <= s + 1'b1;
      end
      if (cmd.mark_found) begin
        found <= 1'b1;
      end
    end
  end

  assign stat.is_root    = (q.par == cur);
  assign stat.root_cyc   = q.cyc;
  assign stat.clear_done = (clr_idx == VERT_W'(NUM_VERT - 1));
  assign stat.scan_done  = (s == limit);
  assign stat.stored     = stored_r;
  assign stat.last       = last_r;
  assign stat.ovf        = ovf;

  assign cycle_found = found;
  assign overflow    = ovf;

endmodule

FILE: hw/rtl/undirected_cycle_detector_unit.sv
// Channel   Direction  Beat contents
// edges     in         edge_u, edge_v, has_edge, last_edge
// results   out        cycle_found, overflow (one beat per last_edge beat)
//
// A beat that stores an edge walks the links to both component roots in the
// forest memory, which has one read port, and then writes two links; a beat
// that stores nothing only passes through the decide state.
// A last_edge beat then scans the start vertices below vertex_count (at most
// 1024) up to the first one in a flagged component, unless the batch overflowed.
// After reset, and after each result beat is taken, a clearing pass rewrites
// all 1024 entries of the forest memory; no edge beat is taken during it.
// The result is held until the sink takes it; no edge beat is taken then.
module undirected_cycle_detector_unit
  import ucd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [VCOUNT_W-1:0] cfg_data,
  ucd_edge_if.sink            edges,
  ucd_result_if.source        results
);

  // Cycle detection runs as union-find while edges arrive: an edge whose
  // endpoints already share a root closes a cycle (this covers self-loops
  // and repeated edges), and the flag travels with the root on each merge.
  // The final scan reports a cycle if any start vertex sits in a flagged
  // component, which matches a walk from every start vertex.
  cmd_t  cmd;
  stat_t stat;

  ucd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (edges.valid),
    .in_ready  (edges.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  ucd_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .edge_u      (edges.edge_u),
    .edge_v      (edges.edge_v),
    .has_edge    (edges.has_edge),
    .last_edge   (edges.last_edge),
    .cmd         (cmd),
    .stat        (stat),
    .cycle_found (results.cycle_found),
    .overflow    (results.overflow)
  );

endmodule

FILE: test/undirected_cycle_detector_unit_tb.sv
`timescale 1ns / 100ps

module undirected_cycle_detector_unit_tb
  import ucd_pkg::*;
;

  // Idle cycles without any accepted beat before the run is declared hung.
  // A scan over 1024 start vertices plus the clearing pass fits well inside.
  localparam int unsigned HANG_LIMIT = 400000;
  // The long receiver hold-off used to fill the block and stall its input.
  localparam int unsigned LONG_HOLD = 2000;
  // Cycles allowed for the clearing pass before a register write or the end.
  localparam int unsigned SETTLE_CYCLES = 1200;

  typedef struct {
    bit cyc;
    bit ovf;
  } verdict_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [VCOUNT_W-1:0] cfg_data;

  ucd_edge_if edges_if ();
  ucd_result_if results_if ();

  undirected_cycle_detector_unit uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .edges    (edges_if),
    .results  (results_if)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Shadow of the batch that the block is collecting, in arrival order.
  int unsigned batch_a[$];
  int unsigned batch_b[$];
  bit batch_ovf;
  int unsigned start_limit;  // vertex_count as written, 11 bits
  verdict_t verdicts_due[$];

  int unsigned error_count;
  int unsigned graphs_sent;
  int unsigned cycles_seen;
  int unsigned overflows_seen;
  int unsigned results_checked;
  int unsigned hold_requests;
  int unsigned hold_served;
  bit no_idle;  // when set, neither side inserts gaps
  int unsigned rx_wait;
  int unsigned idle_cycles;

  // Breadth-first walk over the stored batch. A neighbor that is already
  // marked and is not the parent of the current vertex closes a cycle, so a
  // self-loop and a doubled edge both count.
  function automatic bit batch_has_cycle();
    int unsigned adj[NUM_VERT][$];
    bit marked[NUM_VERT];
    int parent_id[NUM_VERT];
    int unsigned fifo[$];
    int unsigned lim;
    int unsigned cur;
    int unsigned nb;
    foreach (batch_a[i]) begin
      adj[batch_a[i]].insert(adj[batch_a[i]].size(), batch_b[i]);
      adj[batch_b[i]].insert(adj[batch_b[i]].size(), batch_a[i]);
    end
    lim = (start_limit < NUM_VERT) ? start_limit : NUM_VERT;
    for (int unsigned s = 0; s < lim; s++) begin
      if (!marked[s]) begin
        marked[s] = 1'b1;
        parent_id[s] = -1;
        fifo.delete();
        fifo.insert(fifo.size(), s);
        while (fifo.size() > 0) begin
          cur = fifo.pop_front();
          for (int k = 0; k < adj[cur].size(); k++) begin
            nb = adj[cur][k];
            if (marked[nb]) begin
              if (int'(nb) != parent_id[cur]) return 1'b1;
            end else begin
              marked[nb] = 1'b1;
              parent_id[nb] = cur;
              fifo.insert(fifo.size(), nb);
            end
          end
        end
      end
    end
    return 1'b0;
  endfunction

  // Applies one accepted edge beat to the shadow batch; a last beat yields
  // the verdict that the block must report and clears the batch.
  function automatic void absorb_edge(vert_t u, vert_t v, bit has, bit last);
    verdict_t vd;
    if (has) begin
      if (batch_a.size() < MAX_EDGES) begin
        batch_a.insert(batch_a.size(), u);
        batch_b.insert(batch_b.size(), v);
      end else begin
        batch_ovf = 1'b1;
      end
    end
    if (last) begin
      vd.ovf = batch_ovf;
      vd.cyc = batch_ovf ? 1'b0 : batch_has_cycle();
      verdicts_due.insert(verdicts_due.size(), vd);
      batch_a.delete();
      batch_b.delete();
      batch_ovf = 1'b0;
      graphs_sent++;
    end
  endfunction

  // Offers one edge beat and waits until it is taken. Valid is only dropped
  // when a gap follows, so back-to-back beats keep it high.
  task automatic send_edge(vert_t u, vert_t v, bit has, bit last);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      edges_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    edges_if.valid <= 1'b1;
    edges_if.edge_u <= u;
    edges_if.edge_v <= v;
    edges_if.has_edge <= has;
    edges_if.last_edge <= last;
    do @(posedge clk); while (!edges_if.ready);
    absorb_edge(u, v, has, last);
  endtask

  task automatic end_beats();
    edges_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every verdict has come back and the clearing pass is over.
  task automatic drain();
    end_beats();
    wait (verdicts_due.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_vertex_count(int unsigned value);
    drain();
    cfg_write <= 1'b1;
    cfg_data <= VCOUNT_W'(value);
    @(posedge clk);
    cfg_write <= 1'b0;
    start_limit = value & ((1 << VCOUNT_W) - 1);
  endtask

  // Hand-built graphs around each rule of the walk.
  task automatic test_directed_graphs();
    send_edge(10'd0, 10'd0, 1, 1);          // self-loop
    send_edge(10'd1023, 10'd511, 0, 1);     // empty marker alone
    send_edge(10'd1023, 10'd1023, 1, 1);    // self-loop at the top vertex
    send_edge(10'd0, 10'd1, 1, 0);          // triangle
    send_edge(10'd1, 10'd2, 1, 0);
    send_edge(10'd2, 10'd0, 1, 1);
    send_edge(10'd5, 10'd6, 1, 0);          // the same edge twice
    send_edge(10'd6, 10'd5, 1, 1);
    send_edge(10'd3, 10'd4, 1, 0);          // path with an empty beat inside
    send_edge(10'd4, 10'd7, 1, 0);
    send_edge(10'd700, 10'd300, 0, 0);
    send_edge(10'd7, 10'd1022, 1, 1);
    send_edge(10'd682, 10'd341, 1, 0);      // star with alternating bits
    send_edge(10'd682, 10'd0, 1, 0);
    send_edge(10'd682, 10'd1023, 1, 1);
    drain();
  endtask

  // Register extremes: no start vertex at all, only vertices 0 and 1, and the
  // oversize value that acts as the full range.
  task automatic test_vertex_count_extremes();
    write_vertex_count(0);
    send_edge(10'd0, 10'd0, 1, 1);
    write_vertex_count(2);
    send_edge(10'd10, 10'd11, 1, 0);        // cycle out of reach of vertices 0 and 1
    send_edge(10'd11, 10'd12, 1, 0);
    send_edge(10'd12, 10'd10, 1, 1);
    send_edge(10'd1, 10'd9, 1, 0);          // reachable from vertex 1
    send_edge(10'd9, 10'd1, 1, 1);
    write_vertex_count(2047);
    send_edge(10'd1000, 10'd1000, 1, 1);
    write_vertex_count(1024);
    drain();
  endtask

  // One batch with one edge past the store's capacity, then a clean batch
  // to show the overflow mark was cleared.
  task automatic test_edge_overflow();
    for (int unsigned i = 0; i < MAX_EDGES + 1; i++) begin
      send_edge(vert_t'($urandom_range(0, 15)), vert_t'($urandom_range(0, 15)), 1,
                i == MAX_EDGES);
    end
    send_edge(10'd2, 10'd3, 1, 1);
    drain();
  endtask

  // The receiver holds off for a long stretch while graphs keep coming, so
  // the held result stalls the edge input.
  task automatic test_result_backpressure();
    end_beats();
    wait (verdicts_due.size() == 0);
    hold_requests++;
    for (int unsigned g = 0; g < 6; g++) begin
      send_edge(vert_t'(g), vert_t'(g + 1), 1, 0);
      send_edge(vert_t'(g + 1), vert_t'(g * (g & 1)), 1, 1);
    end
    drain();
  endtask

  // Random graphs. Most are trees over a small vertex set, some with an
  // extra edge, so that both verdicts come often; a few use the full range.
  task automatic test_random_graphs();
    int unsigned items;
    int unsigned n_edges;
    int unsigned span;
    int unsigned kind;
    int unsigned batch_no;
    int unsigned counts[7];
    vert_t u;
    vert_t v;
    counts = '{0, 1, 3, 64, 1023, 1024, 2047};
    items = 0;
    batch_no = 0;
    while (items < 800) begin
      if (batch_no % 25 == 24) begin
        if ($urandom_range(0, 2) == 0) write_vertex_count($urandom_range(0, 2047));
        else write_vertex_count(counts[$urandom_range(0, 6)]);
      end
      no_idle = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 9);
      n_edges = $urandom_range(1, 10);
      span = (kind == 0) ? 1023 : $urandom_range(4, 20);
      for (int unsigned i = 0; i < n_edges; i++) begin
        if (kind == 0) begin
          u = vert_t'($urandom);
          v = vert_t'($urandom);
        end else if (kind <= 6 && i > 0) begin
          u = vert_t'(i % (span + 1));
          v = vert_t'($urandom_range(0, i - 1) % (span + 1));
        end else begin
          u = vert_t'($urandom_range(0, span));
          v = vert_t'($urandom_range(0, span));
        end
        send_edge(u, v, $urandom_range(0, 7) != 0, 1'b0);
        items++;
      end
      if (kind == 1) begin
        send_edge(vert_t'($urandom_range(0, n_edges)), vert_t'($urandom_range(0, n_edges)), 1,
                  1);
      end else begin
        send_edge(vert_t'($urandom), vert_t'($urandom), $urandom_range(0, 1) == 1, 1);
      end
      items++;
      batch_no++;
    end
    no_idle = 1'b0;
    drain();
  endtask

  // Receiver: checks each result beat against the oldest verdict, then
  // draws its next wait. A pending long hold-off overrides the draw.
  always @(posedge clk) begin
    verdict_t vd;
    if (rst) begin
      results_if.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (results_if.valid && results_if.ready) begin
        results_checked++;
        if (verdicts_due.size() == 0) begin
          $display("%0t: result beat with none expected: cycle_found=%0b overflow=%0b",
                   $time, results_if.cycle_found, results_if.overflow);
          error_count++;
        end else begin
          vd = verdicts_due.pop_front();
          if (results_if.cycle_found !== vd.cyc) begin
            $display("%0t: cycle_found expected %0b, got %0b", $time, vd.cyc,
                     results_if.cycle_found);
            error_count++;
          end
          if (results_if.overflow !== vd.ovf) begin
            $display("%0t: overflow expected %0b, got %0b", $time, vd.ovf,
                     results_if.overflow);
            error_count++;
          end
          cycles_seen += vd.cyc;
          overflows_seen += vd.ovf;
        end
        rx_wait = no_idle ? 0 : $urandom_range(0, 3);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      if (hold_served < hold_requests) begin
        hold_served++;
        rx_wait = LONG_HOLD;
      end
      results_if.ready <= (rx_wait == 0);
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if ((edges_if.valid && edges_if.ready) || (results_if.valid && results_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, HANG_LIMIT);
        $display("undirected_cycle_detector_unit_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_data <= '0;
    edges_if.valid <= 1'b0;
    edges_if.edge_u <= '0;
    edges_if.edge_v <= '0;
    edges_if.has_edge <= 1'b0;
    edges_if.last_edge <= 1'b0;
    start_limit = VCOUNT_RESET;
    batch_ovf = 1'b0;
    error_count = 0;
    graphs_sent = 0;
    cycles_seen = 0;
    overflows_seen = 0;
    results_checked = 0;
    hold_requests = 0;
    hold_served = 0;
    no_idle = 1'b0;
    idle_cycles = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_directed_graphs();
    test_vertex_count_extremes();
    test_result_backpressure();
    test_edge_overflow();
    test_random_graphs();
    test_result_backpressure();

    drain();
    $display("Covered %0d graphs, %0d results checked: %0d with a cycle, %0d overflowed.",
             graphs_sent, results_checked, cycles_seen, overflows_seen);
    $display("Start-vertex limits from 0 to 2047 and a long result hold-off were exercised.");
    if (error_count == 0) begin
      $display("undirected_cycle_detector_unit_tb: done, clean");
    end else begin
      $display("undirected_cycle_detector_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
